/* rtl/tecpu_pkg.sv */
package tecpu_pkg;

    localparam int PROG_DEPTH_DEF = 256;
    localparam int NUM_REGS       = 6;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [1:0] {
        CLS_IMM  = 2'b00,
        CLS_ALU  = 2'b01,
        CLS_COPY = 2'b10,
        CLS_JUMP = 2'b11
    } class_t;

    localparam logic [2:0] ALU_OR   = 3'd0;
    localparam logic [2:0] ALU_NAND = 3'd1;
    localparam logic [2:0] ALU_NOR  = 3'd2;
    localparam logic [2:0] ALU_AND  = 3'd3;
    localparam logic [2:0] ALU_ADD  = 3'd4;
    localparam logic [2:0] ALU_SUB  = 3'd5;

    localparam logic [2:0] COND_NEVER = 3'd0;
    localparam logic [2:0] COND_EQZ   = 3'd1;
    localparam logic [2:0] COND_LTZ   = 3'd2;
    localparam logic [2:0] COND_LEZ   = 3'd3;
    localparam logic [2:0] COND_ALWAYS = 3'd4;
    localparam logic [2:0] COND_NEZ   = 3'd5;
    localparam logic [2:0] COND_GEZ   = 3'd6;
    localparam logic [2:0] COND_GTZ   = 3'd7;

    localparam logic [2:0] SEL_PORT = 3'd6;
    localparam logic [2:0] SEL_NONE = 3'd7;

    localparam logic [2:0] REG_IMM = 3'd0;
    localparam logic [2:0] REG_A   = 3'd1;
    localparam logic [2:0] REG_B   = 3'd2;
    localparam logic [2:0] REG_RES = 3'd3;

    typedef struct packed {
        logic       halted;
        logic       jump_taken;
        logic [7:0] next_pc;
        logic       out_written;
        logic [7:0] out_value;
    } result_t;

    function automatic logic [7:0] alu_op(input logic [2:0] op, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] old);
        logic [7:0] r;
        unique case (op)
            ALU_OR:   r = a | b;
            ALU_NAND: r = ~(a & b);
            ALU_NOR:  r = ~(a | b);
            ALU_AND:  r = a & b;
            ALU_ADD:  r = a + b;
            ALU_SUB:  r = a - b;
            default:  r = old;
        endcase
        return r;
    endfunction

    function automatic logic cond_holds(input logic [2:0] c, input logic [7:0] v);
        logic neg;
        logic zero;
        logic r;
        neg  = v[7];
        zero = (v == 8'd0);
        unique case (c)
            COND_NEVER:  r = 1'b0;
            COND_EQZ:    r = zero;
            COND_LTZ:    r = neg;
            COND_LEZ:    r = neg | zero;
            COND_ALWAYS: r = 1'b1;
            COND_NEZ:    r = ~zero;
            COND_GEZ:    r = ~neg;
            COND_GTZ:    r = ~neg & ~zero;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tecpu_prog_mem.sv */
module tecpu_prog_mem
    import tecpu_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [7:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic [7:0] rd_addr,
    output logic [7:0] instr
);

    localparam int         AW      = $clog2(PROG_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(PROG_DEPTH);

    logic [7:0]            prog_mem_reg [PROG_DEPTH];
    logic [7:0]            rdata_reg;
    logic [PROG_DEPTH-1:0] valid_reg;
    logic                  rvalid_reg;
    logic                  rvalid_next;
    logic                  byp_hit_reg;
    logic                  byp_hit_next;
    logic [7:0]            byp_data_reg;
    logic                  wr_ok;
    logic                  rd_ok;
    logic [AW-1:0]         wr_idx;
    logic [AW-1:0]         rd_idx;

    assign wr_idx = wr_addr[AW-1:0];
    assign rd_idx = rd_addr[AW-1:0];
    assign wr_ok  = wr_en && ({1'b0, wr_addr} < DEPTH_W);
    assign rd_ok  = {1'b0, rd_addr} < DEPTH_W;

    assign byp_hit_next = wr_ok && (wr_addr == rd_addr);
    assign rvalid_next  = rd_ok && valid_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            prog_mem_reg[wr_idx] <= wr_data;
        end
        rdata_reg    <= prog_mem_reg[rd_idx];
        byp_data_reg <= wr_data;
    end

    // per-entry valid bits stand in for clearing the store at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            rvalid_reg  <= 1'b0;
            byp_hit_reg <= 1'b0;
        end else begin
            if (wr_ok) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rvalid_reg  <= rvalid_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    always_comb begin
        if (byp_hit_reg) begin
            instr = byp_data_reg;
        end else if (rvalid_reg) begin
            instr = rdata_reg;
        end else begin
            instr = 8'd0;
        end
    end

endmodule

/* rtl/tecpu_exec.sv */
module tecpu_exec
    import tecpu_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] instr,
    input  logic [7:0] in_value,
    output logic [7:0] pc_cur,
    output logic [7:0] pc_next,
    output result_t    res
);

    localparam logic [8:0] DEPTH_W = 9'(PROG_DEPTH);

    logic [7:0] pc_reg;
    logic [7:0] rf_reg  [NUM_REGS];
    logic [7:0] rf_next [NUM_REGS];

    always_comb begin
        logic       run;
        logic [2:0] src;
        logic [2:0] dst;
        logic [7:0] src_val;
        class_t     cls;
        src = instr[5:3];
        dst = instr[2:0];
        cls = class_t'(instr[7:6]);
        if (src < 3'(NUM_REGS)) begin
            src_val = rf_reg[src];
        end else if (src == SEL_PORT) begin
            src_val = in_value;
        end else begin
            src_val = 8'd0;
        end

        run     = step_en && ({1'b0, pc_reg} < DEPTH_W);
        pc_next = pc_reg;
        rf_next = rf_reg;
        res     = '0;

        if (run) begin
            pc_next = pc_reg + 8'd1;
            unique case (cls)
                CLS_IMM: begin
                    rf_next[REG_IMM] = {2'b00, instr[5:0]};
                end
                CLS_ALU: begin
                    rf_next[REG_RES] = alu_op(instr[2:0], rf_reg[REG_A], rf_reg[REG_B],
                                              rf_reg[REG_RES]);
                end
                CLS_COPY: begin
                    if (dst < 3'(NUM_REGS)) begin
                        rf_next[dst] = src_val;
                    end else if (dst == SEL_PORT) begin
                        res.out_value   = src_val;
                        res.out_written = 1'b1;
                    end
                end
                CLS_JUMP: begin
                    if (cond_holds(instr[2:0], rf_reg[REG_RES])) begin
                        pc_next        = rf_reg[REG_IMM];
                        res.jump_taken = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        res.next_pc = pc_next;
        res.halted  = {1'b0, pc_next} >= DEPTH_W;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 8'd0;
            rf_reg <= '{default: 8'd0};
        end else begin
            pc_reg <= pc_next;
            rf_reg <= rf_next;
        end
    end

    assign pc_cur = pc_reg;

endmodule

/* rtl/tiny_eight_bit_cpu_core.sv */
// Eight-bit CPU core driven one word at a time.
// Input stream: s_tuser is the kind (0 = load a program byte, 1 = execute one
// instruction); s_tdata carries load address, load byte and the input port byte.
// Output stream: one result word per input word with the output port byte,
// its write flag, the pc after the word, jump flag and halt flag.
// The result is registered and shows on m_* in the cycle after accept.
// Throughput: one word per cycle while m_* is not stalled. The instruction
// at the next pc is fetched from the synchronous program store in the same
// cycle the pc is updated, and a load to that address is forwarded, so steps
// and loads may follow each other with no bubble.
// Reset (aresetn low, synchronous): pc and all six registers go to zero and
// the program store reads as zero everywhere; the core is ready immediately.
// Stall: a stalled result word holds on m_*; one more input word is taken
// only when the output register empties in the same cycle.
module tiny_eight_bit_cpu_core
    import tecpu_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // load_address, load_word, in_value
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // out_value, out_written, next_pc, jump_taken, halted, zero pad
);

    logic       s_acc;
    logic       step_en;
    logic       load_en;
    logic [7:0] instr;
    logic [7:0] pc_cur;
    logic [7:0] pc_next;
    result_t    res;
    result_t    m_res_reg;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign step_en  = s_acc && (s_tuser == KIND_STEP);
    assign load_en  = s_acc && (s_tuser == KIND_LOAD);

    tecpu_prog_mem #(
        .PROG_DEPTH(PROG_DEPTH)
    ) u_prog_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_en),
        .wr_addr (s_tdata[7:0]),
        .wr_data (s_tdata[15:8]),
        .rd_addr (pc_next),
        .instr   (instr)
    );

    tecpu_exec #(
        .PROG_DEPTH(PROG_DEPTH)
    ) u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .instr    (instr),
        .in_value (s_tdata[23:16]),
        .pc_cur   (pc_cur),
        .pc_next  (pc_next),
        .res      (res)
    );

    assign m_tvalid_next = s_acc || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_res_reg};

`ifndef ASSERT_OFF
    a_jump_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_res_reg.jump_taken |-> !m_res_reg.out_written)
        else $error("jump and output write in one word");

    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_res_reg.out_written |-> m_res_reg.out_value == 8'd0)
        else $error("output byte nonzero without write");

    a_load_keeps_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |=> m_res_reg.next_pc == $past(pc_cur) && pc_cur == $past(pc_cur))
        else $error("load word moved the pc");
`endif

endmodule
